// ===== sv/lmts_pkg.sv =====
// Shared types and constants for the LCD mode timing sequencer.
// No dependencies; used by every other file of the block.
`default_nettype none

package lmts_pkg;

  // Mode codes as they appear on lcd_mode_o
  localparam logic [1:0] ModeHblank = 2'd0;
  localparam logic [1:0] ModeVblank = 2'd1;
  localparam logic [1:0] ModeOam    = 2'd2;
  localparam logic [1:0] ModeVram   = 2'd3;

  localparam int unsigned AccWidth   = 10;
  localparam int unsigned DeltaWidth = 7;
  localparam int unsigned LineWidth  = 8;

  localparam logic [AccWidth-1:0] LenOam    = 10'd80;
  localparam logic [AccWidth-1:0] LenVram   = 10'd172;
  localparam logic [AccWidth-1:0] LenHblank = 10'd204;
  localparam logic [AccWidth-1:0] LenLine   = 10'd456;

  localparam logic [LineWidth-1:0] LastVisibleLine = 8'd143;
  localparam logic [LineWidth-1:0] LastLine        = 8'd153;

  localparam logic [7:0] StatMatch  = 8'b0100_0100;
  localparam logic [7:0] StatOam    = 8'b0010_0010;
  localparam logic [7:0] StatHblank = 8'b0000_1000;
  localparam logic [7:0] StatVblank = 8'b0001_0001;
  localparam logic [7:0] StatVram   = 8'b0000_0011;

  // Register index decoded from paddr
  localparam logic RegLineCompare = 1'b0;

  typedef struct packed {
    logic [AccWidth-1:0]  acc;
    logic [1:0]           mode;
    logic [LineWidth-1:0] line;
  } timing_state_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [LineWidth-1:0] line;
    logic                 match;
    logic [7:0]           status;
    logic                 vblank_req;
    logic                 render;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/lcd_mode_timing_sequencer_core.sv =====
// LCD mode timing sequencer. Each input beat carries the machine cycles elapsed
// since the previous one; the block steps the OAM / VRAM / HBlank / VBlank
// sequence by at most one mode change and returns exactly one result beat with
// mode, line, compare flag, status byte and the vblank and render pulses.
// Throughput is one beat per clock while the output side is not stalled: the delta
// is captured in an input register, stepped combinationally against the timing
// state, and the result lands in an output register, where it stays offered until
// it is taken.
// Write line_compare only while idle.
// Depends on lmts_pkg, lmts_cfg and lmts_step.
`default_nettype none

module lcd_mode_timing_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [6:0]  delta_cycles_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       lcd_mode_o,
  output logic [7:0]       line_number_o,
  output logic             line_match_o,
  output logic [7:0]       status_byte_o,
  output logic             vblank_request_o,
  output logic             render_line_o
);

  logic [7:0] line_compare;

  logic       in_valid_q, in_valid_d;
  logic [6:0] delta_q, delta_d;
  logic       out_valid_q, out_valid_d;
  logic       advance;

  lmts_pkg::timing_state_t state_q, state_d, step_state;
  lmts_pkg::result_t       result_q, result_d, step_result;

  lmts_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .line_compare_o (line_compare)
  );

  lmts_step u_step (
    .state_i        (state_q),
    .delta_i        (delta_q),
    .line_compare_i (line_compare),
    .state_o        (step_state),
    .result_o       (step_result)
  );

  // step the held beat when the output register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    delta_d     = delta_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    result_d    = result_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      in_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      state_d     = step_state;
      result_d    = step_result;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      delta_d    = delta_cycles_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.acc   <= '0;
      state_q.mode  <= lmts_pkg::ModeOam;
      state_q.line  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    result_q <= result_d;
  end

  assign out_valid_o      = out_valid_q;
  assign lcd_mode_o       = result_q.mode;
  assign line_number_o    = result_q.line;
  assign line_match_o     = result_q.match;
  assign status_byte_o    = result_q.status;
  assign vblank_request_o = result_q.vblank_req;
  assign render_line_o    = result_q.render;

endmodule

`default_nettype wire

// ===== sv/lmts_cfg.sv =====
// APB-style register port holding the line-compare value.
// Depends on lmts_pkg for the register index.
`default_nettype none

module lmts_cfg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [7:0]      line_compare_o
);

  logic [7:0] line_compare_q, line_compare_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lmts_pkg::RegLineCompare);

  always_comb begin
    line_compare_d = line_compare_q;
    if (wr_en) begin
      line_compare_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_compare_q <= 8'd0;
    end else begin
      line_compare_q <= line_compare_d;
    end
  end

  // Low address bits are ignored: byte lanes of the same word
  assign prdata = (paddr[2] == lmts_pkg::RegLineCompare) ? {24'd0, line_compare_q} : 32'd0;
  assign line_compare_o = line_compare_q;

endmodule

`default_nettype wire

// ===== sv/lmts_step.sv =====
// One timing step: add the elapsed cycles, make at most one mode change,
// and build the result fields. Pure combinational; depends on lmts_pkg.
`default_nettype none

module lmts_step (
  input  wire lmts_pkg::timing_state_t state_i,
  input  wire logic [lmts_pkg::DeltaWidth-1:0] delta_i,
  input  wire logic [lmts_pkg::LineWidth-1:0]  line_compare_i,
  output lmts_pkg::timing_state_t state_o,
  output lmts_pkg::result_t       result_o
);

  logic [lmts_pkg::AccWidth-1:0]  sum;
  logic [lmts_pkg::LineWidth-1:0] line_inc;
  logic                           vblank_req;
  logic                           render;
  logic                           match;
  logic [7:0]                     mode_bits;

  assign sum      = state_i.acc + {{(lmts_pkg::AccWidth-lmts_pkg::DeltaWidth){1'b0}}, delta_i};
  assign line_inc = state_i.line + 8'd1;

  always_comb begin
    state_o     = state_i;
    state_o.acc = sum;
    vblank_req  = 1'b0;
    render      = 1'b0;
    unique case (state_i.mode)
      lmts_pkg::ModeOam: begin
        if (sum >= lmts_pkg::LenOam) begin
          state_o.acc  = sum - lmts_pkg::LenOam;
          state_o.mode = lmts_pkg::ModeVram;
        end
      end
      lmts_pkg::ModeVram: begin
        if (sum >= lmts_pkg::LenVram) begin
          state_o.acc  = sum - lmts_pkg::LenVram;
          state_o.mode = lmts_pkg::ModeHblank;
          state_o.line = line_inc;
          render       = 1'b1;
        end
      end
      lmts_pkg::ModeHblank: begin
        if (sum >= lmts_pkg::LenHblank) begin
          state_o.acc = sum - lmts_pkg::LenHblank;
          if (state_i.line > lmts_pkg::LastVisibleLine) begin
            state_o.mode = lmts_pkg::ModeVblank;
            vblank_req   = 1'b1;
          end else begin
            state_o.mode = lmts_pkg::ModeOam;
          end
        end
      end
      default: begin
        if (sum >= lmts_pkg::LenLine) begin
          state_o.acc = sum - lmts_pkg::LenLine;
          // wrap to the top of the frame after the last vblank line
          if (line_inc > lmts_pkg::LastLine) begin
            state_o.mode = lmts_pkg::ModeOam;
            state_o.line = '0;
          end else begin
            state_o.line = line_inc;
          end
        end
      end
    endcase
  end

  assign match = (state_o.line == line_compare_i);

  always_comb begin
    unique case (state_o.mode)
      lmts_pkg::ModeOam:    mode_bits = lmts_pkg::StatOam;
      lmts_pkg::ModeHblank: mode_bits = lmts_pkg::StatHblank;
      lmts_pkg::ModeVblank: mode_bits = lmts_pkg::StatVblank;
      default:              mode_bits = lmts_pkg::StatVram;
    endcase
  end

  always_comb begin
    result_o.mode       = state_o.mode;
    result_o.line       = state_o.line;
    result_o.match      = match;
    result_o.status     = (match ? lmts_pkg::StatMatch : 8'd0) | mode_bits;
    result_o.vblank_req = vblank_req;
    result_o.render     = render;
  end

endmodule

`default_nettype wire

// ===== sv/lmts_checker.sv =====
// Port-level checks for the LCD mode timing sequencer, bound to the top level.
// Depends on lmts_pkg for the mode codes and the line bounds.
`default_nettype none

module lmts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] lcd_mode_o,
  input wire logic [7:0] line_number_o,
  input wire logic       line_match_o,
  input wire logic [7:0] status_byte_o,
  input wire logic       vblank_request_o,
  input wire logic       render_line_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // vblank lines only
  a_vblank_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lcd_mode_o == lmts_pkg::ModeVblank)
      |-> (line_number_o > lmts_pkg::LastVisibleLine) && (line_number_o <= lmts_pkg::LastLine))
    else $error("vblank mode outside vblank lines");

  // render pulse only in hblank, vblank request only in vblank
  a_pulse_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!render_line_o || (lcd_mode_o == lmts_pkg::ModeHblank))
                 && (!vblank_request_o || (lcd_mode_o == lmts_pkg::ModeVblank)))
    else $error("pulse in wrong mode");

  a_status_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_byte_o[6] == line_match_o) && (status_byte_o[2] == line_match_o))
    else $error("status byte disagrees with line match");

endmodule

bind lcd_mode_timing_sequencer_core lmts_checker u_lmts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .lcd_mode_o       (lcd_mode_o),
  .line_number_o    (line_number_o),
  .line_match_o     (line_match_o),
  .status_byte_o    (status_byte_o),
  .vblank_request_o (vblank_request_o),
  .render_line_o    (render_line_o)
);

`default_nettype wire
